### rtl/ale_pkg.sv
// Shared types and codes for the array list engine.
package ale_pkg;

   localparam int CMD_W    = 3;
   localparam int IDX_W    = 5;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = 5;

   localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_GET     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SET     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd6;
   localparam logic [CMD_W-1:0] CMD_STATS   = 3'd7;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [DATA_W-1:0]   read_value;
      logic [DATA_W-1:0]   max_value;
      logic [DATA_W-1:0]   min_value;
      logic [DATA_W-1:0]   mean_value;
      logic [CNT_W-1:0]    count;
   } result_type;

endpackage

### rtl/array_list_engine_unit.sv
// Top level of the array list engine: command sequencer and result register.
//
// Usage: one request on req_* (command, index, value) gives exactly one
// result on rsp_* (status, found, read_value, max/min/mean, count).
// Both channels are valid/ready. req_ready is high only while the
// sequencer is idle; a new request may be taken while the previous
// result still waits in the output register.
// Work per request: append, set and errors finish in decode; get does one read.
// Insert and delete read and write each entry moved; search reads and
// compares each entry until the key is found; reverse reads both entries
// of each pair and writes them back swapped; statistics reads each entry,
// updates max then min, then divides the sum by the count, where the sum has
// SUM_W = min(64, WIDTH + clog2(DEPTH+1)) bits; 37 at the defaults.
// req_ready rises together with rsp_valid, so the next request can be
// taken as soon as the result appears.
// All list walks go through the one storage block; search and statistics
// share the one comparator, and the mean comes from a bit-serial divider.
// Reset clears the count and the control state; stored entries are not
// cleared. A stalled result holds rsp_* steady; the sequencer waits in
// its final state until the output register frees up.
module array_list_engine_unit #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ale_pkg::CMD_W-1:0]            req_command,
   input  logic [ale_pkg::IDX_W-1:0]            req_index,
   input  logic signed [WIDTH-1:0]              req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ale_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                 rsp_found,
   output logic signed [ale_pkg::DATA_W-1:0]    rsp_read_value,
   output logic signed [ale_pkg::DATA_W-1:0]    rsp_max_value,
   output logic signed [ale_pkg::DATA_W-1:0]    rsp_min_value,
   output logic signed [ale_pkg::DATA_W-1:0]    rsp_mean_value,
   output logic [ale_pkg::CNT_W-1:0]            rsp_count
);

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = (CW > ale_pkg::IDX_W) ? CW : ale_pkg::IDX_W;
   localparam int SUM_W = (WIDTH + CW > 64) ? 64 : WIDTH + CW;
   localparam int DW    = ale_pkg::DATA_W;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DECODE  = 5'd1;
   localparam logic [4:0] S_INS_RD  = 5'd2;
   localparam logic [4:0] S_INS_WR  = 5'd3;
   localparam logic [4:0] S_DEL_RD  = 5'd4;
   localparam logic [4:0] S_DEL_WR  = 5'd5;
   localparam logic [4:0] S_SR_RD   = 5'd6;
   localparam logic [4:0] S_SR_CMP  = 5'd7;
   localparam logic [4:0] S_GET_WT  = 5'd8;
   localparam logic [4:0] S_REV_RDA = 5'd9;
   localparam logic [4:0] S_REV_RDB = 5'd10;
   localparam logic [4:0] S_REV_WRA = 5'd11;
   localparam logic [4:0] S_REV_WRB = 5'd12;
   localparam logic [4:0] S_ST_RD   = 5'd13;
   localparam logic [4:0] S_ST_MAX  = 5'd14;
   localparam logic [4:0] S_ST_MIN  = 5'd15;
   localparam logic [4:0] S_DIV     = 5'd16;
   localparam logic [4:0] S_DONE    = 5'd17;

   logic [4:0]                    state_ff, state_in;
   logic [ale_pkg::CMD_W-1:0]     cmd_ff, cmd_in;
   logic [PW-1:0]                 idx_ff, idx_in;
   logic [WIDTH-1:0]              val_ff, val_in;
   logic [PW-1:0]                 ptr_ff, ptr_in;
   logic [PW-1:0]                 hi_ff, hi_in;
   logic [WIDTH-1:0]              tmp_ff, tmp_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [ale_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                          found_ff, found_in;
   logic [DW-1:0]                 rd_ff, rd_in;
   logic [WIDTH-1:0]              mx_ff, mx_in;
   logic [WIDTH-1:0]              mn_ff, mn_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [DW-1:0]                 mean_ff, mean_in;
   ale_pkg::result_type           rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic [PW-1:0]    n_pw;
   logic [PW-1:0]    ptr_p1;
   logic [PW-1:0]    ptr_m1;
   logic [PW-1:0]    cnt_pw;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [WIDTH-1:0] mem_wdata;
   logic             mem_re;
   logic [AW-1:0]    mem_raddr;
   logic [WIDTH-1:0] rd_data;
   logic [WIDTH-1:0] alu_a;
   logic [WIDTH-1:0] alu_b;
   logic             alu_eq;
   logic             alu_lt;
   logic             sum_neg;
   logic [SUM_W-1:0] sum_mag;
   logic             div_start;
   logic             div_done;
   logic [SUM_W-1:0] div_quo;
   logic [SUM_W-1:0] mean_full;

   ale_store #(.DEPTH(DEPTH), .WIDTH(WIDTH), .AW(AW)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (rd_data)
   );

   ale_cmp #(.WIDTH(WIDTH)) u_cmp (
      .a  (alu_a),
      .b  (alu_b),
      .eq (alu_eq),
      .lt (alu_lt)
   );

   ale_div #(.SUM_W(SUM_W), .DIV_W(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign n_pw      = PW'(count_ff);
   assign ptr_p1    = ptr_ff + PW'(1);
   assign ptr_m1    = ptr_ff - PW'(1);
   assign sum_neg   = sum_ff[SUM_W-1];
   assign sum_mag   = sum_neg ? (~sum_ff + SUM_W'(1)) : sum_ff;
   assign mean_full = sum_neg ? (~div_quo + SUM_W'(1)) : div_quo;
   assign cnt_pw    = PW'(count_ff);

   // shared comparator operand select
   always_comb begin
      alu_a = val_ff;
      alu_b = rd_data;
      if (state_ff == S_ST_MAX) begin
         alu_a = mx_ff;
      end else if (state_ff == S_ST_MIN) begin
         alu_a = rd_data;
         alu_b = mn_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      ptr_in       = ptr_ff;
      hi_in        = hi_ff;
      tmp_in       = tmp_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      rd_in        = rd_ff;
      mx_in        = mx_ff;
      mn_in        = mn_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff[AW-1:0];
      mem_wdata    = val_ff;
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff[AW-1:0];
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_command;
               idx_in    = PW'(req_index);
               val_in    = req_value;
               status_in = ale_pkg::STATUS_OK;
               found_in  = 1'b0;
               rd_in     = '0;
               mx_in     = '0;
               mn_in     = '0;
               mean_in   = '0;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_DONE;
            unique case (cmd_ff)
               ale_pkg::CMD_APPEND: begin
                  if (n_pw == PW'(DEPTH)) begin
                     status_in = ale_pkg::STATUS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = n_pw[AW-1:0];
                     count_in  = count_ff + CW'(1);
                  end
               end
               ale_pkg::CMD_INSERT: begin
                  if (n_pw == PW'(DEPTH)) begin
                     status_in = ale_pkg::STATUS_FULL;
                  end else if (idx_ff > n_pw) begin
                     status_in = ale_pkg::STATUS_RANGE;
                  end else begin
                     ptr_in   = n_pw;
                     state_in = S_INS_RD;
                  end
               end
               ale_pkg::CMD_DELETE: begin
                  if (idx_ff >= n_pw) begin
                     status_in = ale_pkg::STATUS_RANGE;
                  end else begin
                     ptr_in   = idx_ff;
                     state_in = S_DEL_RD;
                  end
               end
               ale_pkg::CMD_SEARCH: begin
                  ptr_in   = '0;
                  state_in = S_SR_RD;
               end
               ale_pkg::CMD_GET: begin
                  if (idx_ff >= n_pw) begin
                     status_in = ale_pkg::STATUS_RANGE;
                  end else begin
                     mem_re    = 1'b1;
                     mem_raddr = idx_ff[AW-1:0];
                     state_in  = S_GET_WT;
                  end
               end
               ale_pkg::CMD_SET: begin
                  if (idx_ff >= n_pw) begin
                     status_in = ale_pkg::STATUS_RANGE;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = idx_ff[AW-1:0];
                  end
               end
               ale_pkg::CMD_REVERSE: begin
                  if (n_pw >= PW'(2)) begin
                     ptr_in   = '0;
                     hi_in    = n_pw - PW'(1);
                     state_in = S_REV_RDA;
                  end
               end
               ale_pkg::CMD_STATS: begin
                  if (n_pw == '0) begin
                     status_in = ale_pkg::STATUS_EMPTY;
                  end else begin
                     ptr_in   = '0;
                     sum_in   = '0;
                     state_in = S_ST_RD;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_INS_RD: begin
            if (ptr_ff == idx_ff) begin
               mem_we    = 1'b1;
               mem_waddr = idx_ff[AW-1:0];
               count_in  = count_ff + CW'(1);
               state_in  = S_DONE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ptr_m1[AW-1:0];
               state_in  = S_INS_WR;
            end
         end
         S_INS_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data;
            ptr_in    = ptr_m1;
            state_in  = S_INS_RD;
         end
         S_DEL_RD: begin
            if (ptr_p1 < n_pw) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_p1[AW-1:0];
               state_in  = S_DEL_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_DONE;
            end
         end
         S_DEL_WR: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data;
            ptr_in    = ptr_p1;
            state_in  = S_DEL_RD;
         end
         S_SR_RD: begin
            if (ptr_ff < n_pw) begin
               mem_re   = 1'b1;
               state_in = S_SR_CMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SR_CMP: begin
            if (alu_eq) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else begin
               ptr_in   = ptr_p1;
               state_in = S_SR_RD;
            end
         end
         S_GET_WT: begin
            rd_in    = DW'(signed'(rd_data));
            state_in = S_DONE;
         end
         S_REV_RDA: begin
            if (ptr_ff < hi_ff) begin
               mem_re   = 1'b1;
               state_in = S_REV_RDB;
            end else begin
               state_in = S_DONE;
            end
         end
         S_REV_RDB: begin
            // low entry arrives now; fetch the high one
            tmp_in    = rd_data;
            mem_re    = 1'b1;
            mem_raddr = hi_ff[AW-1:0];
            state_in  = S_REV_WRA;
         end
         S_REV_WRA: begin
            mem_we    = 1'b1;
            mem_wdata = rd_data;
            state_in  = S_REV_WRB;
         end
         S_REV_WRB: begin
            mem_we    = 1'b1;
            mem_waddr = hi_ff[AW-1:0];
            mem_wdata = tmp_ff;
            ptr_in    = ptr_p1;
            hi_in     = hi_ff - PW'(1);
            state_in  = S_REV_RDA;
         end
         S_ST_RD: begin
            mem_re   = 1'b1;
            state_in = S_ST_MAX;
         end
         S_ST_MAX: begin
            if (ptr_ff == '0) begin
               mx_in = rd_data;
               mn_in = rd_data;
            end else if (alu_lt) begin
               mx_in = rd_data;
            end
            sum_in   = sum_ff + SUM_W'(signed'(rd_data));
            state_in = S_ST_MIN;
         end
         S_ST_MIN: begin
            if (alu_lt) begin
               mn_in = rd_data;
            end
            if (ptr_p1 < n_pw) begin
               ptr_in   = ptr_p1;
               state_in = S_ST_RD;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               mean_in  = DW'(signed'(mean_full));
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.status     = status_ff;
               rsp_in.found      = found_ff;
               rsp_in.read_value = rd_ff;
               rsp_in.max_value  = DW'(signed'(mx_ff));
               rsp_in.min_value  = DW'(signed'(mn_ff));
               rsp_in.mean_value = mean_ff;
               rsp_in.count      = cnt_pw[ale_pkg::CNT_W-1:0];
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      ptr_ff    <= ptr_in;
      hi_ff     <= hi_in;
      tmp_ff    <= tmp_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rd_ff     <= rd_in;
      mx_ff     <= mx_in;
      mn_ff     <= mn_in;
      sum_ff    <= sum_in;
      mean_ff   <= mean_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_found      = rsp_ff.found;
   assign rsp_read_value = rsp_ff.read_value;
   assign rsp_max_value  = rsp_ff.max_value;
   assign rsp_min_value  = rsp_ff.min_value;
   assign rsp_mean_value = rsp_ff.mean_value;
   assign rsp_count      = rsp_ff.count;

endmodule

### rtl/ale_store.sv
// Element storage: one write port, one registered read port.
module ale_store #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/ale_cmp.sv
// Shared signed comparator used by search and statistics.
module ale_cmp #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic             eq,
   output logic             lt
);

   assign eq = (a == b);
   assign lt = ($signed(a) < $signed(b));

endmodule

### rtl/ale_div.sv
// Restoring divider, one quotient bit per cycle.
module ale_div #(
   parameter int SUM_W = 37,
   parameter int DIV_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int BCW = $clog2(SUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [BCW-1:0]   bits_ff, bits_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      ge    = (trial >= {1'b0, divisor});
      diff  = trial - {1'b0, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         bits_in = BCW'(SUM_W);
         quo_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         rem_in  = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         bits_in = bits_ff - BCW'(1);
         if (bits_ff == BCW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         bits_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         bits_ff <= bits_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/ale_checker.sv
// Port-level assertions for the array list engine, bound to the top level.
module ale_checker #(
   parameter int DEPTH = 16
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [ale_pkg::STATUS_W-1:0]      rsp_status,
   input logic                              rsp_found,
   input logic [ale_pkg::DATA_W-1:0]        rsp_max_value,
   input logic [ale_pkg::DATA_W-1:0]        rsp_min_value,
   input logic [ale_pkg::DATA_W-1:0]        rsp_mean_value,
   input logic [ale_pkg::CNT_W-1:0]         rsp_count
);

   // one request at a time: busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while busy");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_count) && $stable(rsp_status)
          && $stable(rsp_mean_value)))
      else $error("stalled result changed");

   // empty statistics report zeros
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ale_pkg::STATUS_EMPTY) |->
         (rsp_max_value == '0 && rsp_min_value == '0 && rsp_mean_value == '0
          && rsp_count == '0))
      else $error("empty statistics with nonzero fields");

   // found only on success, count within bounds
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |->
         (rsp_status == ale_pkg::STATUS_OK && rsp_count != '0))
      else $error("found with error status or empty list");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_count) <= 32'(DEPTH) || DEPTH > 31))
      else $error("count above depth");

endmodule

bind array_list_engine_unit ale_checker #(.DEPTH(DEPTH)) u_ale_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_found      (rsp_found),
   .rsp_max_value  (rsp_max_value),
   .rsp_min_value  (rsp_min_value),
   .rsp_mean_value (rsp_mean_value),
   .rsp_count      (rsp_count)
);

### test/list_result_checker.sv
// Checker for the array list engine: predicts each result and compares it.
`timescale 1ns / 100ps

module list_result_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [ale_pkg::CMD_W-1:0]         req_command,
   input  logic [ale_pkg::IDX_W-1:0]         req_index,
   input  logic signed [ale_pkg::DATA_W-1:0] req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [ale_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                              rsp_found,
   input  logic signed [ale_pkg::DATA_W-1:0] rsp_read_value,
   input  logic signed [ale_pkg::DATA_W-1:0] rsp_max_value,
   input  logic signed [ale_pkg::DATA_W-1:0] rsp_min_value,
   input  logic signed [ale_pkg::DATA_W-1:0] rsp_mean_value,
   input  logic [ale_pkg::CNT_W-1:0]         rsp_count,
   output int                                failures,
   output int                                pending
);
   import ale_pkg::*;

   localparam int LIST_DEPTH = 16;
   localparam int MAX_REPORTS = 40;

   logic signed [DATA_W-1:0] list_entries [LIST_DEPTH];
   int                       list_size = 0;
   result_type               expected_results [$];
   int                       result_number = 0;

   initial failures = 0;
   assign pending = expected_results.size();

   task automatic report_mismatch(input string what);
      failures++;
      if (failures <= MAX_REPORTS)
         $display("%0t: result %0d: %s", $realtime, result_number, what);
   endtask

   function automatic result_type apply_list_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic signed [DATA_W-1:0] val);
      result_type               r;
      int                       pos;
      longint                   total;
      logic signed [DATA_W-1:0] held;
      longint                   quotient;
      r = '0;
      pos = int'(idx);
      case (cmd)
         CMD_APPEND: begin
            if (list_size >= LIST_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               list_entries[list_size] = val;
               list_size++;
            end
         end
         CMD_INSERT: begin
            if (list_size >= LIST_DEPTH) begin
               r.status = STATUS_FULL;
            end else if (pos > list_size) begin
               r.status = STATUS_RANGE;
            end else begin
               for (int i = list_size; i > pos; i--)
                  list_entries[i] = list_entries[i-1];
               list_entries[pos] = val;
               list_size++;
            end
         end
         CMD_DELETE: begin
            if (pos >= list_size) begin
               r.status = STATUS_RANGE;
            end else begin
               for (int i = pos; i + 1 < list_size; i++)
                  list_entries[i] = list_entries[i+1];
               list_size--;
            end
         end
         CMD_SEARCH: begin
            for (int i = 0; i < list_size; i++)
               if (list_entries[i] == val)
                  r.found = 1'b1;
         end
         CMD_GET: begin
            if (pos >= list_size)
               r.status = STATUS_RANGE;
            else
               r.read_value = list_entries[pos];
         end
         CMD_SET: begin
            if (pos >= list_size)
               r.status = STATUS_RANGE;
            else
               list_entries[pos] = val;
         end
         CMD_REVERSE: begin
            for (int i = 0; i < list_size / 2; i++) begin
               held = list_entries[i];
               list_entries[i] = list_entries[list_size-1-i];
               list_entries[list_size-1-i] = held;
            end
         end
         default: begin
            if (list_size == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               total = 0;
               r.max_value = list_entries[0];
               r.min_value = list_entries[0];
               for (int i = 0; i < list_size; i++) begin
                  if ($signed(list_entries[i]) > $signed(r.max_value))
                     r.max_value = list_entries[i];
                  if ($signed(list_entries[i]) < $signed(r.min_value))
                     r.min_value = list_entries[i];
                  total += longint'(list_entries[i]);
               end
               quotient = total / longint'(list_size);
               r.mean_value = quotient[DATA_W-1:0];
            end
         end
      endcase
      r.count = CNT_W'(list_size);
      return r;
   endfunction

   task automatic compare_result();
      result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("unexpected result, no request outstanding");
         return;
      end
      want = expected_results.pop_front();
      if (rsp_status !== want.status)
         report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
      if (rsp_found !== want.found)
         report_mismatch($sformatf("found %0d, expected %0d", rsp_found, want.found));
      if (rsp_read_value !== want.read_value)
         report_mismatch($sformatf("read_value %0d, expected %0d",
                                   rsp_read_value, $signed(want.read_value)));
      if (rsp_max_value !== want.max_value)
         report_mismatch($sformatf("max_value %0d, expected %0d",
                                   rsp_max_value, $signed(want.max_value)));
      if (rsp_min_value !== want.min_value)
         report_mismatch($sformatf("min_value %0d, expected %0d",
                                   rsp_min_value, $signed(want.min_value)));
      if (rsp_mean_value !== want.mean_value)
         report_mismatch($sformatf("mean_value %0d, expected %0d",
                                   rsp_mean_value, $signed(want.mean_value)));
      if (rsp_count !== want.count)
         report_mismatch($sformatf("count %0d, expected %0d", rsp_count, want.count));
      result_number++;
   endtask

   // results first: a result can never belong to a request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            compare_result();
         if (req_valid === 1'b1 && req_ready === 1'b1)
            expected_results.push_back(apply_list_command(req_command, req_index, req_value));
      end
   end

endmodule

### test/testbench.sv
// Top of the array list engine testbench: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module testbench;
   import ale_pkg::*;

   localparam int          CYCLE_LIMIT = 1000000;
   localparam int          RANDOM_PER_PHASE = 370;
   localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7FFFFFFF;
   localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh80000000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CMD_W-1:0]           req_command = CMD_APPEND;
   logic [IDX_W-1:0]           req_index = '0;
   logic signed [DATA_W-1:0]   req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_found;
   logic signed [DATA_W-1:0]   rsp_read_value;
   logic signed [DATA_W-1:0]   rsp_max_value;
   logic signed [DATA_W-1:0]   rsp_min_value;
   logic signed [DATA_W-1:0]   rsp_mean_value;
   logic [CNT_W-1:0]           rsp_count;

   int failures;
   int pending;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int cycles = 0;

   logic signed [DATA_W-1:0] value_pool [8] = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1, 1, 5, -5,
                                                 100};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   array_list_engine_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_read_value(rsp_read_value),
      .rsp_max_value (rsp_max_value),
      .rsp_min_value (rsp_min_value),
      .rsp_mean_value(rsp_mean_value),
      .rsp_count     (rsp_count)
   );

   list_result_checker result_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_index     (req_index),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_found     (rsp_found),
      .rsp_read_value(rsp_read_value),
      .rsp_max_value (rsp_max_value),
      .rsp_min_value (rsp_min_value),
      .rsp_mean_value(rsp_mean_value),
      .rsp_count     (rsp_count),
      .failures      (failures),
      .pending       (pending)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // valid stays high across back-to-back requests; it drops only for idle cycles
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_index   <= idx;
      req_value   <= val;
      do
         @(posedge clock);
      while (req_ready !== 1'b1);
   endtask

   task automatic run_random(input int items, input bit grow);
      int                       r;
      logic [CMD_W-1:0]         cmd;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] val;
      for (int k = 0; k < items; k++) begin
         if (k % 48 == 0)
            grow = 1'($urandom_range(1));
         r = $urandom_range(99);
         if (grow)
            cmd = (r < 35) ? CMD_APPEND : (r < 55) ? CMD_INSERT : (r < 60) ? CMD_DELETE :
                  CMD_W'(3 + $urandom_range(4));
         else
            cmd = (r < 10) ? CMD_APPEND : (r < 20) ? CMD_INSERT : (r < 50) ? CMD_DELETE :
                  CMD_W'(3 + $urandom_range(4));
         idx = ($urandom_range(9) < 8) ? IDX_W'($urandom_range(16)) : IDX_W'($urandom_range(31));
         case ($urandom_range(3))
            0:       val = value_pool[$urandom_range(7)];
            1:       val = $signed(DATA_W'($urandom_range(15))) - 8;
            default: val = $urandom;
         endcase
         send_request(cmd, idx, val);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      send_request(CMD_STATS, '0, 0);
      send_request(CMD_SEARCH, '0, 0);
      send_request(CMD_REVERSE, '0, 0);
      send_request(CMD_DELETE, '0, 0);
      send_request(CMD_INSERT, IDX_W'(1), 7);
      send_request(CMD_GET, '0, 0);
      // small list: extremes, insert at end, bad indexes
      send_request(CMD_INSERT, '0, MAX_WORD);
      send_request(CMD_REVERSE, '0, 0);
      send_request(CMD_APPEND, IDX_W'(31), MIN_WORD);
      send_request(CMD_INSERT, IDX_W'(2), -1);
      send_request(CMD_GET, IDX_W'(31), 0);
      send_request(CMD_SET, IDX_W'(3), 9);
      send_request(CMD_STATS, '0, 0);
      send_request(CMD_REVERSE, '0, 0);
      send_request(CMD_SEARCH, '0, MIN_WORD);
      send_request(CMD_GET, '0, 0);
      send_request(CMD_SET, IDX_W'(1), 0);
      send_request(CMD_DELETE, IDX_W'(2), 0);
      send_request(CMD_SEARCH, '0, 12345);
      // fill to capacity, then overflow
      for (int i = 0; i < 14; i++)
         send_request(CMD_APPEND, '0, MAX_WORD - i);
      send_request(CMD_APPEND, '0, 1);
      send_request(CMD_INSERT, '0, 1);
      send_request(CMD_STATS, '0, 0);

      run_random(RANDOM_PER_PHASE, 1'b1);
      send_idle_pct = 82;
      run_random(RANDOM_PER_PHASE, 1'b0);
      send_idle_pct = 0;
      rsp_stall_pct = 82;
      run_random(RANDOM_PER_PHASE, 1'b1);
      send_idle_pct = 6;
      rsp_stall_pct = 6;
      run_random(RANDOM_PER_PHASE, 1'b0);
      req_valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;

      while (pending != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      if (failures == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
